/* sv/rvdec_pkg.sv */
`default_nettype none

package rvdec_pkg;

    // Major opcodes
    localparam logic [6:0] OP_LUI    = 7'b0110111;
    localparam logic [6:0] OP_AUIPC  = 7'b0010111;
    localparam logic [6:0] OP_JAL    = 7'b1101111;
    localparam logic [6:0] OP_JALR   = 7'b1100111;
    localparam logic [6:0] OP_BRANCH = 7'b1100011;
    localparam logic [6:0] OP_LOAD   = 7'b0000011;
    localparam logic [6:0] OP_STORE  = 7'b0100011;
    localparam logic [6:0] OP_IMM    = 7'b0010011;
    localparam logic [6:0] OP_REG    = 7'b0110011;
    localparam logic [6:0] OP_FENCE  = 7'b0001111;
    localparam logic [6:0] OP_SYSTEM = 7'b1110011;
    localparam logic [6:0] OP_AMO    = 7'b0101111;

    localparam logic [6:0] FUNCT7_M  = 7'b0000001;

    // A-extension funct5 codes
    localparam logic [4:0] F5_LR      = 5'h02;
    localparam logic [4:0] F5_SC      = 5'h03;
    localparam logic [4:0] F5_AMOSWAP = 5'h01;
    localparam logic [4:0] F5_AMOADD  = 5'h00;
    localparam logic [4:0] F5_AMOXOR  = 5'h04;
    localparam logic [4:0] F5_AMOAND  = 5'h0C;
    localparam logic [4:0] F5_AMOOR   = 5'h08;
    localparam logic [4:0] F5_AMOMIN  = 5'h10;
    localparam logic [4:0] F5_AMOMAX  = 5'h14;
    localparam logic [4:0] F5_AMOMINU = 5'h18;
    localparam logic [4:0] F5_AMOMAXU = 5'h1C;

    // Dense mnemonic codes
    localparam logic [5:0] MN_LUI   = 6'd0,  MN_AUIPC = 6'd1,  MN_JAL   = 6'd2;
    localparam logic [5:0] MN_JALR  = 6'd3;
    localparam logic [5:0] MN_BEQ   = 6'd4,  MN_BNE   = 6'd5,  MN_BLT   = 6'd6;
    localparam logic [5:0] MN_BGE   = 6'd7,  MN_BLTU  = 6'd8,  MN_BGEU  = 6'd9;
    localparam logic [5:0] MN_LB    = 6'd10, MN_LH    = 6'd11, MN_LW    = 6'd12;
    localparam logic [5:0] MN_LBU   = 6'd13, MN_LHU   = 6'd14;
    localparam logic [5:0] MN_SB    = 6'd15;
    localparam logic [5:0] MN_ADDI  = 6'd18, MN_SLTI  = 6'd19, MN_SLTIU = 6'd20;
    localparam logic [5:0] MN_XORI  = 6'd21, MN_ORI   = 6'd22, MN_ANDI  = 6'd23;
    localparam logic [5:0] MN_SLLI  = 6'd24, MN_SRLI  = 6'd25, MN_SRAI  = 6'd26;
    localparam logic [5:0] MN_ADD   = 6'd27, MN_SUB   = 6'd28, MN_SLL   = 6'd29;
    localparam logic [5:0] MN_SLT   = 6'd30, MN_SLTU  = 6'd31, MN_XOR   = 6'd32;
    localparam logic [5:0] MN_SRL   = 6'd33, MN_SRA   = 6'd34, MN_OR    = 6'd35;
    localparam logic [5:0] MN_AND   = 6'd36;
    localparam logic [5:0] MN_MUL   = 6'd37;
    localparam logic [5:0] MN_FENCE = 6'd45, MN_FENCEI = 6'd46, MN_PAUSE = 6'd47;
    localparam logic [5:0] MN_ECALL = 6'd48, MN_EBREAK = 6'd49;
    localparam logic [5:0] MN_LR    = 6'd50, MN_SC    = 6'd51, MN_AMOSWAP = 6'd52;
    localparam logic [5:0] MN_AMOADD = 6'd53, MN_AMOXOR = 6'd54, MN_AMOAND = 6'd55;
    localparam logic [5:0] MN_AMOOR  = 6'd56, MN_AMOMIN = 6'd57, MN_AMOMAX = 6'd58;
    localparam logic [5:0] MN_AMOMINU = 6'd59, MN_AMOMAXU = 6'd60;
    localparam logic [5:0] MN_LAST  = MN_AMOMAXU;

    localparam int IN_W  = 64;
    localparam int OUT_W = 96;

    typedef enum logic [3:0] {
        FMT_NONE, FMT_U, FMT_J, FMT_I, FMT_SH, FMT_S, FMT_B, FMT_R, FMT_A, FMT_F
    } fmt_t;

    typedef struct packed {
        logic        is_valid;
        logic [5:0]  mnemonic_code;
        logic [4:0]  dest_reg;
        logic [4:0]  src1_reg;
        logic [4:0]  src2_reg;
        logic [31:0] immediate;
        logic [31:0] jump_target;
        logic        acquire_bit;
        logic        release_bit;
        logic [3:0]  fence_pred;
        logic [3:0]  fence_succ;
    } dec_result_t;

endpackage

`default_nettype wire

/* sv/rv32ima_instruction_decoder.sv */
// RV32IMA instruction decoder, streaming in and out.
//
// Slave side (s_axis_*): one transaction carries an instruction word in
// tdata[31:0] and its address in tdata[63:32]. No tlast or tuser.
// Master side (m_axis_*): one transaction per instruction with the decoded
// fields in tdata (see port comment). An unknown word gives is_valid = 0 and
// every other field zero.
//
// Pipeline: input register -> combinational decode -> result register.
// Each accepted instruction passes the input register, then the result
// register. Throughput is one instruction per cycle while m_axis_tready is
// high; the decode and the 32-bit target adder sit between the two registers.
//
// The ready chain runs back through both stages, so a stalled receiver only
// holds the stage in front of it; with both stages full and m_axis_tready
// low, s_axis_tready drops in the same cycle. Nothing is lost or repeated.
//
// Reset (rst_n low, asynchronous) empties both stages; no result is pending
// afterwards. The decoder itself holds no state.
`default_nettype none

module rv32ima_instruction_decoder (
    input  wire logic                        clk,
    input  wire logic                        rst_n,

    input  wire logic                        s_axis_tvalid,
    output      logic                        s_axis_tready,
    // [31:0] instruction_word, [63:32] pc_address
    input  wire logic [rvdec_pkg::IN_W-1:0]  s_axis_tdata,

    output      logic                        m_axis_tvalid,
    input  wire logic                        m_axis_tready,
    // [0] is_valid, [6:1] mnemonic_code, [11:7] dest_reg, [16:12] src1_reg,
    // [21:17] src2_reg, [53:22] immediate, [85:54] jump_target,
    // [86] acquire_bit, [87] release_bit, [91:88] fence_pred, [95:92] fence_succ
    output      logic [rvdec_pkg::OUT_W-1:0] m_axis_tdata
);

    // Stage 1: captured instruction word and address
    logic                   in_valid_reg;
    logic [31:0]            word_reg;
    logic [31:0]            pc_reg;

    // Stage 2: decoded result
    logic                   out_valid_reg;
    rvdec_pkg::dec_result_t res_reg;
    rvdec_pkg::dec_result_t res_next;

    logic                   out_free;   // result stage can take a new entry
    logic                   in_adv;     // stage 1 moves into stage 2 this cycle

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign in_adv        = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            word_reg <= s_axis_tdata[31:0];
            pc_reg   <= s_axis_tdata[63:32];
        end
    end

    rvdec_decode u_decode (
        .instruction_word (word_reg),
        .pc_address       (pc_reg),
        .result           (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_adv)
        begin
            res_reg <= res_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {res_reg.fence_succ, res_reg.fence_pred,
                            res_reg.release_bit, res_reg.acquire_bit,
                            res_reg.jump_target, res_reg.immediate,
                            res_reg.src2_reg, res_reg.src1_reg, res_reg.dest_reg,
                            res_reg.mnemonic_code, res_reg.is_valid};

    // An invalid word carries nothing but zeros
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !res_reg.is_valid) |-> (res_reg == '0))
        else $error("invalid decode with non-zero fields");

    // Mnemonic code stays within the defined range
    a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (res_reg.mnemonic_code <= rvdec_pkg::MN_LAST))
        else $error("mnemonic code out of range");

    // A full stage 1 with room downstream yields a result next cycle
    a_advance: assert property (@(posedge clk) disable iff (!rst_n)
        in_adv |=> out_valid_reg)
        else $error("stage 1 entry lost");

    // Input back-pressure only when both stages are occupied
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (in_valid_reg && out_valid_reg && !m_axis_tready))
        else $error("input stalled without cause");

endmodule

`default_nettype wire

/* sv/rvdec_decode.sv */
`default_nettype none

// Single-pass combinational decode of one instruction word.
module rvdec_decode (
    input  wire logic [31:0]        instruction_word,
    input  wire logic [31:0]        pc_address,
    output rvdec_pkg::dec_result_t  result
);

    logic [31:0]       w;
    logic [6:0]        opc;
    logic [2:0]        f3;
    logic              b30;
    logic              ok;
    logic [5:0]        code;
    rvdec_pkg::fmt_t   fmt;
    logic [31:0]       imm_u, imm_i, imm_s, imm_b, imm_j, br_off;
    logic [31:0]       target;

    assign w   = instruction_word;
    assign opc = w[6:0];
    assign f3  = w[14:12];
    assign b30 = w[30];

    assign imm_u = {{12{w[31]}}, w[31:12]};
    assign imm_i = {{20{w[31]}}, w[31:20]};
    assign imm_s = {{20{w[31]}}, w[31:25], w[11:7]};
    assign imm_b = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
    assign imm_j = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};

    assign br_off = (fmt == rvdec_pkg::FMT_J) ? imm_j : imm_b;
    assign target = pc_address + br_off;

    // Mnemonic and format selection
    always_comb
    begin
        ok   = 1'b1;
        code = rvdec_pkg::MN_LUI;
        fmt  = rvdec_pkg::FMT_NONE;
        case (opc)
            rvdec_pkg::OP_LUI:
            begin
                code = rvdec_pkg::MN_LUI;
                fmt  = rvdec_pkg::FMT_U;
            end
            rvdec_pkg::OP_AUIPC:
            begin
                code = rvdec_pkg::MN_AUIPC;
                fmt  = rvdec_pkg::FMT_U;
            end
            rvdec_pkg::OP_JAL:
            begin
                code = rvdec_pkg::MN_JAL;
                fmt  = rvdec_pkg::FMT_J;
            end
            rvdec_pkg::OP_JALR:
            begin
                code = rvdec_pkg::MN_JALR;
                fmt  = rvdec_pkg::FMT_I;
            end
            rvdec_pkg::OP_BRANCH:
            begin
                fmt = rvdec_pkg::FMT_B;
                case (f3)
                    3'd0:    code = rvdec_pkg::MN_BEQ;
                    3'd1:    code = rvdec_pkg::MN_BNE;
                    3'd4:    code = rvdec_pkg::MN_BLT;
                    3'd5:    code = rvdec_pkg::MN_BGE;
                    3'd6:    code = rvdec_pkg::MN_BLTU;
                    3'd7:    code = rvdec_pkg::MN_BGEU;
                    default: ok = 1'b0;
                endcase
            end
            rvdec_pkg::OP_LOAD:
            begin
                fmt = rvdec_pkg::FMT_I;
                case (f3)
                    3'd0:    code = rvdec_pkg::MN_LB;
                    3'd1:    code = rvdec_pkg::MN_LH;
                    3'd2:    code = rvdec_pkg::MN_LW;
                    3'd4:    code = rvdec_pkg::MN_LBU;
                    3'd5:    code = rvdec_pkg::MN_LHU;
                    default: ok = 1'b0;
                endcase
            end
            rvdec_pkg::OP_STORE:
            begin
                fmt  = rvdec_pkg::FMT_S;
                code = rvdec_pkg::MN_SB + {3'b000, f3};
                ok   = (f3 inside {3'd0, 3'd1, 3'd2});
            end
            rvdec_pkg::OP_IMM:
            begin
                fmt = (f3 inside {3'd1, 3'd5}) ? rvdec_pkg::FMT_SH : rvdec_pkg::FMT_I;
                case (f3)
                    3'd0:    code = rvdec_pkg::MN_ADDI;
                    3'd1:    code = rvdec_pkg::MN_SLLI;
                    3'd2:    code = rvdec_pkg::MN_SLTI;
                    3'd3:    code = rvdec_pkg::MN_SLTIU;
                    3'd4:    code = rvdec_pkg::MN_XORI;
                    3'd5:    code = b30 ? rvdec_pkg::MN_SRAI : rvdec_pkg::MN_SRLI;
                    3'd6:    code = rvdec_pkg::MN_ORI;
                    default: code = rvdec_pkg::MN_ANDI;
                endcase
            end
            rvdec_pkg::OP_REG:
            begin
                fmt = rvdec_pkg::FMT_R;
                if (w[31:25] == rvdec_pkg::FUNCT7_M)
                begin
                    code = rvdec_pkg::MN_MUL + {3'b000, f3};
                end
                else
                begin
                    case (f3)
                        3'd0:    code = b30 ? rvdec_pkg::MN_SUB : rvdec_pkg::MN_ADD;
                        3'd1:    code = rvdec_pkg::MN_SLL;
                        3'd2:    code = rvdec_pkg::MN_SLT;
                        3'd3:    code = rvdec_pkg::MN_SLTU;
                        3'd4:    code = rvdec_pkg::MN_XOR;
                        3'd5:    code = b30 ? rvdec_pkg::MN_SRA : rvdec_pkg::MN_SRL;
                        3'd6:    code = rvdec_pkg::MN_OR;
                        default: code = rvdec_pkg::MN_AND;
                    endcase
                end
            end
            rvdec_pkg::OP_FENCE:
            begin
                case (f3)
                    3'd0:
                    begin
                        fmt = rvdec_pkg::FMT_F;
                        // pause: fm zero, pred = w only, succ empty
                        if (w[31:28] == 4'd0 && w[27:24] == 4'd1 && w[23:20] == 4'd0)
                            code = rvdec_pkg::MN_PAUSE;
                        else
                            code = rvdec_pkg::MN_FENCE;
                    end
                    3'd1:
                    begin
                        fmt  = rvdec_pkg::FMT_I;
                        code = rvdec_pkg::MN_FENCEI;
                    end
                    default: ok = 1'b0;
                endcase
            end
            rvdec_pkg::OP_SYSTEM:
            begin
                fmt  = rvdec_pkg::FMT_I;
                code = w[20] ? rvdec_pkg::MN_EBREAK : rvdec_pkg::MN_ECALL;
            end
            rvdec_pkg::OP_AMO:
            begin
                fmt = rvdec_pkg::FMT_A;
                case (w[31:27])
                    rvdec_pkg::F5_LR:      code = rvdec_pkg::MN_LR;
                    rvdec_pkg::F5_SC:      code = rvdec_pkg::MN_SC;
                    rvdec_pkg::F5_AMOSWAP: code = rvdec_pkg::MN_AMOSWAP;
                    rvdec_pkg::F5_AMOADD:  code = rvdec_pkg::MN_AMOADD;
                    rvdec_pkg::F5_AMOXOR:  code = rvdec_pkg::MN_AMOXOR;
                    rvdec_pkg::F5_AMOAND:  code = rvdec_pkg::MN_AMOAND;
                    rvdec_pkg::F5_AMOOR:   code = rvdec_pkg::MN_AMOOR;
                    rvdec_pkg::F5_AMOMIN:  code = rvdec_pkg::MN_AMOMIN;
                    rvdec_pkg::F5_AMOMAX:  code = rvdec_pkg::MN_AMOMAX;
                    rvdec_pkg::F5_AMOMINU: code = rvdec_pkg::MN_AMOMINU;
                    rvdec_pkg::F5_AMOMAXU: code = rvdec_pkg::MN_AMOMAXU;
                    default:               ok = 1'b0;
                endcase
            end
            default: ok = 1'b0;
        endcase
    end

    // Field gating per format; everything zero for an invalid word
    always_comb
    begin
        result = '0;
        if (ok)
        begin
            result.is_valid      = 1'b1;
            result.mnemonic_code = code;
            case (fmt)
                rvdec_pkg::FMT_U:
                begin
                    result.dest_reg  = w[11:7];
                    result.immediate = imm_u;
                end
                rvdec_pkg::FMT_J:
                begin
                    result.dest_reg    = w[11:7];
                    result.immediate   = imm_j;
                    result.jump_target = target;
                end
                rvdec_pkg::FMT_I:
                begin
                    result.dest_reg  = w[11:7];
                    result.src1_reg  = w[19:15];
                    result.immediate = imm_i;
                end
                rvdec_pkg::FMT_SH:
                begin
                    result.dest_reg  = w[11:7];
                    result.src1_reg  = w[19:15];
                    result.src2_reg  = w[24:20];
                    result.immediate = imm_i;
                end
                rvdec_pkg::FMT_S:
                begin
                    result.src1_reg  = w[19:15];
                    result.src2_reg  = w[24:20];
                    result.immediate = imm_s;
                end
                rvdec_pkg::FMT_B:
                begin
                    result.src1_reg    = w[19:15];
                    result.src2_reg    = w[24:20];
                    result.immediate   = imm_b;
                    result.jump_target = target;
                end
                rvdec_pkg::FMT_R:
                begin
                    result.dest_reg = w[11:7];
                    result.src1_reg = w[19:15];
                    result.src2_reg = w[24:20];
                end
                rvdec_pkg::FMT_A:
                begin
                    result.dest_reg    = w[11:7];
                    result.src1_reg    = w[19:15];
                    result.src2_reg    = w[24:20];
                    result.acquire_bit = w[26];
                    result.release_bit = w[25];
                end
                rvdec_pkg::FMT_F:
                begin
                    result.dest_reg   = w[11:7];
                    result.src1_reg   = w[19:15];
                    result.immediate  = imm_i;
                    result.fence_pred = w[27:24];
                    result.fence_succ = w[23:20];
                end
                default: result = '0;
            endcase
        end
    end

endmodule

`default_nettype wire
